FILE: src/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the two-key max-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Action codes of a request; the last code is ignored by the block.
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_PEEK = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  // Record field widths.
  localparam int TAG_W   = 32;
  localparam int ROLL_W  = 16;
  localparam int MARKS_W = 16;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_READ,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // latch the request's record
    logic set_drop;      // flag the push as discarded
    logic pop_dec;       // remove the best record
    logic rd_top;        // start the insertion scan at the best record
    logic shift_step;    // move the scanned record up one place
    logic place_here;    // write the new record above the scanned one
    logic place_bottom;  // write the new record at the lowest place
    logic rd_best;       // read the best record for the response
    logic resp;          // present the response
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic better;        // new record strictly better than the scanned one
    logic idx_zero;      // scan has reached the lowest place
  } status_t;

endpackage

FILE: src/max_priority_queue_two_key_top.sv
// ----------------------------------------------------------------------------
// max_priority_queue_two_key_top
// Bounded max-priority queue of records ordered by marks, then by roll.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The action selects
// push, peek or pop; tag_in, roll_in and marks_in matter for a push only.
// Action code 3 is ignored and gives no response.
// Each request gives one response, shown for exactly one cycle while done is
// high: the best record held once the request is served (highest marks, then
// smallest roll, then earliest pushed), is_empty when nothing is held, and
// dropped when a push met a full store. The receiver cannot stall; the
// response must be taken then. A peek, a pop or a push into a full store goes
// straight to the read and response states; a push into an empty store first
// writes the new record at the lowest place. Any other push first runs an
// insertion scan from the best record down, moving one record per cycle
// through a memory with one read and one write port. busy falls in the cycle
// after done, so the next request can be taken in that cycle at the earliest.
// After reset the queue is empty; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module max_priority_queue_two_key_top
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [TAG_W-1:0]   tag_in,
  input  logic [ROLL_W-1:0]  roll_in,
  input  logic [MARKS_W-1:0] marks_in,
  output logic               done,
  output logic               is_empty,
  output logic               dropped,
  output logic [TAG_W-1:0]   tag_out,
  output logic [ROLL_W-1:0]  roll_out,
  output logic [MARKS_W-1:0] marks_out
);

  cmd_t    cmd;
  status_t status;

  // Request sequencing.
  mpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Record storage and response.
  mpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .tag_in    (tag_in),
    .roll_in   (roll_in),
    .marks_in  (marks_in),
    .status    (status),
    .done      (done),
    .is_empty  (is_empty),
    .dropped   (dropped),
    .tag_out   (tag_out),
    .roll_out  (roll_out),
    .marks_out (marks_out)
  );

endmodule

FILE: src/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Controller state machine: sequences push, peek and pop requests.
// ----------------------------------------------------------------------------
module mpq_ctrl
  import mpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  status_t    status,
  output logic       busy,
  output cmd_t       cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_PUSH: begin
              cmd.load = 1'b1;
              if (status.full) begin
                cmd.set_drop = 1'b1;
                state_next   = ST_READ;
              end else if (status.empty) begin
                state_next = ST_PLACE;
              end else begin
                cmd.rd_top = 1'b1;
                state_next = ST_SHIFT;
              end
            end
            ACT_PEEK: begin
              cmd.load   = 1'b1;
              state_next = ST_READ;
            end
            ACT_POP: begin
              cmd.load    = 1'b1;
              cmd.pop_dec = 1'b1;
              state_next  = ST_READ;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (status.better) begin
          cmd.place_here = 1'b1;
          state_next     = ST_READ;
        end else begin
          cmd.shift_step = 1'b1;
          if (status.idx_zero) begin
            state_next = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        cmd.place_bottom = 1'b1;
        state_next       = ST_READ;
      end
      ST_READ: begin
        cmd.rd_best = 1'b1;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        cmd.resp   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/mpq_dp.sv
// ----------------------------------------------------------------------------
// mpq_dp
// Datapath: sorted record memory (worst at address 0, best at the top),
// occupancy count, scan index and response fields.
// ----------------------------------------------------------------------------
module mpq_dp
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [TAG_W-1:0]   tag_in,
  input  logic [ROLL_W-1:0]  roll_in,
  input  logic [MARKS_W-1:0] marks_in,
  output status_t            status,
  output logic               done,
  output logic               is_empty,
  output logic               dropped,
  output logic [TAG_W-1:0]   tag_out,
  output logic [ROLL_W-1:0]  roll_out,
  output logic [MARKS_W-1:0] marks_out
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int OW    = $clog2(CAPACITY + 1);
  localparam int REC_W = TAG_W + ROLL_W + MARKS_W;

  logic [REC_W-1:0] mem [CAPACITY];
  logic [REC_W-1:0] rd_data;
  logic [REC_W-1:0] rec;
  logic [OW-1:0]    occ;
  logic [AW-1:0]    idx;
  logic             drop_flag;

  logic [OW-1:0]    occ_m1;
  logic [AW-1:0]    top_addr;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [REC_W-1:0] wr_data;
  logic [MARKS_W-1:0] m_new, m_old;
  logic [ROLL_W-1:0]  r_new, r_old;

  assign occ_m1   = occ - OW'(1);
  assign top_addr = occ_m1[AW-1:0];

  // Key comparison of the new record against the scanned one.
  assign m_new = rec[MARKS_W-1:0];
  assign r_new = rec[MARKS_W +: ROLL_W];
  assign m_old = rd_data[MARKS_W-1:0];
  assign r_old = rd_data[MARKS_W +: ROLL_W];

  assign status.better   = (m_new > m_old) || ((m_new == m_old) && (r_new < r_old));
  assign status.full     = (occ == OW'(CAPACITY));
  assign status.empty    = (occ == '0);
  assign status.idx_zero = (idx == '0);

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = top_addr;
    wr_en   = 1'b0;
    wr_addr = idx + AW'(1);
    wr_data = rec;
    if (cmd.rd_top || cmd.rd_best) begin
      rd_en = 1'b1;
    end
    if (cmd.shift_step) begin
      rd_en   = 1'b1;
      rd_addr = idx - AW'(1);
      wr_en   = 1'b1;
      wr_data = rd_data;
    end
    if (cmd.place_here) begin
      wr_en = 1'b1;
    end
    if (cmd.place_bottom) begin
      wr_en   = 1'b1;
      wr_addr = '0;
    end
  end

  // Record memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Latched request record and scan index.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec <= {tag_in, roll_in, marks_in};
    end
    if (cmd.rd_top) begin
      idx <= top_addr;
    end else if (cmd.shift_step) begin
      idx <= idx - AW'(1);
    end
  end

  // Occupancy and drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      drop_flag <= 1'b0;
    end else begin
      if (cmd.load) begin
        drop_flag <= cmd.set_drop;
      end
      if (cmd.place_here || cmd.place_bottom) begin
        occ <= occ + OW'(1);
      end else if (cmd.pop_dec && !status.empty) begin
        occ <= occ_m1;
      end
    end
  end

  // Response fields, zero when the queue is empty.
  assign done      = cmd.resp;
  assign is_empty  = status.empty;
  assign dropped   = drop_flag;
  assign tag_out   = status.empty ? '0 : rd_data[REC_W-1 -: TAG_W];
  assign roll_out  = status.empty ? '0 : r_old;
  assign marks_out = status.empty ? '0 : m_old;

endmodule
